@@ hw/rtl/stfr_pkg.sv @@
package stfr_pkg;

   localparam int MAX_FRAME  = 64;
   localparam int HALF_DEPTH = (MAX_FRAME + 1) / 2;
   localparam int HALF_AW    = $clog2(HALF_DEPTH);

   localparam logic [8:0] LEN_MAX    = 9'(MAX_FRAME);
   localparam logic [7:0] LEN_MIN    = 8'd5;
   localparam logic [7:0] BASIC_LEN  = 8'd34;
   localparam logic [7:0] FULL_LEN   = 8'd42;
   localparam logic [7:0] BODY_START = 8'd3;
   localparam logic [7:0] HEAD1_RST  = 8'd170;
   localparam logic [7:0] HEAD2_RST  = 8'd85;

   localparam logic [4:0] LAST_IDX_BASIC = 5'd14;
   localparam logic [4:0] LAST_IDX_FULL  = 5'd18;

   // word n lives at byte offset 4+2n, i.e. half-address 2+n
   localparam logic [HALF_AW-1:0] WORD_BASE = HALF_AW'(2);

   typedef enum logic [0:0] {
      CSR_HEADER_FIRST  = 1'b0,
      CSR_HEADER_SECOND = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_WORD     = 2'd0,
      KIND_CSUM_ERR = 2'd1,
      KIND_SHORT    = 2'd2,
      KIND_BAD_LEN  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] frame_kind;
      logic       full;
   } job_type;

   typedef struct packed {
      logic               en_even;
      logic               en_odd;
      logic [HALF_AW-1:0] addr;
      logic [7:0]         data;
   } store_wr_type;

endpackage

@@ hw/rtl/stfr_ram.sv @@
module stfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/stfr_queue.sv @@
module stfr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  stfr_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output stfr_pkg::job_type head_job
);

   import stfr_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign full       = count_ff[1];
   assign head_valid = (count_ff != 2'd0);
   assign head_job   = entry_ff[rd_ptr_ff];

endmodule

@@ hw/rtl/stfr_front.sv @@
module stfr_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   input  logic                   csr_valid,
   input  stfr_pkg::csr_index_type csr_index,
   input  logic [7:0]             csr_data,
   output logic                   push,
   output stfr_pkg::job_type      push_job,
   input  logic                   queue_full,
   input  logic                   words_done,
   output stfr_pkg::store_wr_type store_wr
);

   import stfr_pkg::*;

   typedef enum logic [3:0] {
      F_HEAD1 = 4'b0001,
      F_HEAD2 = 4'b0010,
      F_LEN   = 4'b0100,
      F_BODY  = 4'b1000
   } front_state_type;

   front_state_type state_ff, state_in;
   logic [7:0] head1_ff, head1_in;
   logic [7:0] head2_ff, head2_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] fkind_ff, fkind_in;
   logic       busy_ff, busy_in;
   logic       accept;

   assign req_stall = queue_full || busy_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      head1_in = head1_ff;
      head2_in = head2_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HEADER_FIRST:  head1_in = csr_data;
            CSR_HEADER_SECOND: head2_in = csr_data;
            default:           head1_in = head1_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      fkind_in = fkind_ff;
      busy_in  = busy_ff;
      push     = 1'b0;
      push_job = '{kind: KIND_WORD, frame_kind: fkind_ff, full: 1'b0};
      store_wr = '{en_even: 1'b0, en_odd: 1'b0, addr: pos_ff[HALF_AW:1],
                   data: req_rx_byte};
      if (words_done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         unique case (state_ff)
            F_HEAD2: begin
               if (req_rx_byte == head2_ff) begin
                  sum_in   = sum_ff + req_rx_byte;
                  state_in = F_LEN;
               end else begin
                  state_in = F_HEAD1;
               end
            end
            F_LEN: begin
               if (req_rx_byte < LEN_MIN || {1'b0, req_rx_byte} > LEN_MAX) begin
                  push     = 1'b1;
                  push_job = '{kind: KIND_BAD_LEN, frame_kind: 8'd0, full: 1'b0};
                  state_in = F_HEAD1;
               end else begin
                  len_in   = req_rx_byte;
                  sum_in   = sum_ff + req_rx_byte;
                  pos_in   = BODY_START;
                  state_in = F_BODY;
               end
            end
            F_BODY: begin
               store_wr.en_even = ~pos_ff[0];
               store_wr.en_odd  = pos_ff[0];
               if (pos_ff == BODY_START) begin
                  fkind_in = req_rx_byte;
               end
               if ((pos_ff + 8'd1) < len_ff) begin
                  sum_in = sum_ff + req_rx_byte;
                  pos_in = pos_ff + 8'd1;
               end else begin
                  state_in = F_HEAD1;
                  push     = 1'b1;
                  priority if (req_rx_byte != sum_ff) begin
                     push_job.kind = KIND_CSUM_ERR;
                  end else if (len_ff < BASIC_LEN) begin
                     push_job.kind = KIND_SHORT;
                  end else begin
                     push_job.kind = KIND_WORD;
                     push_job.full = (len_ff >= FULL_LEN);
                     busy_in       = 1'b1;
                  end
               end
            end
            default: begin
               if (req_rx_byte == head1_ff) begin
                  sum_in   = req_rx_byte;
                  state_in = F_HEAD2;
               end else begin
                  sum_in   = 8'd0;
                  state_in = F_HEAD1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_HEAD1;
         head1_ff <= HEAD1_RST;
         head2_ff <= HEAD2_RST;
         len_ff   <= 8'd0;
         pos_ff   <= 8'd0;
         sum_ff   <= 8'd0;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head1_ff <= head1_in;
         head2_ff <= head2_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         busy_ff  <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      fkind_ff <= fkind_in;
   end

endmodule

@@ hw/rtl/stfr_back.sv @@
module stfr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  stfr_pkg::job_type             head_job,
   output logic                          pop,
   output logic                          words_done,
   output logic [stfr_pkg::HALF_AW-1:0]  rd_addr,
   input  logic [7:0]                    rd_hi,
   input  logic [7:0]                    rd_lo,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [4:0]                    rsp_word_index,
   output logic signed [15:0]            rsp_word_value,
   output logic [7:0]                    rsp_frame_kind,
   output logic                          rsp_last
);

   import stfr_pkg::*;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_READ = 3'b010,
      B_LOAD = 3'b100
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [4:0]         idx_ff, idx_in;
   logic [4:0]         last_idx_ff, last_idx_in;
   logic [7:0]         fkind_ff, fkind_in;
   logic [HALF_AW-1:0] addr_ff, addr_in;

   logic               valid_ff, valid_in;
   kind_type           kind_ff, kind_in;
   logic [4:0]         oidx_ff, oidx_in;
   logic [15:0]        value_ff, value_in;
   logic [7:0]         ofkind_ff, ofkind_in;
   logic               last_ff, last_in;

   logic               slot_free;
   logic               load;

   assign slot_free = !valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      fkind_in    = fkind_ff;
      addr_in     = addr_ff;
      pop         = 1'b0;
      words_done  = 1'b0;
      load        = 1'b0;
      kind_in     = kind_ff;
      oidx_in     = oidx_ff;
      value_in    = value_ff;
      ofkind_in   = ofkind_ff;
      last_in     = last_ff;
      unique case (state_ff)
         B_READ: state_in = B_LOAD;
         B_LOAD: begin
            if (slot_free) begin
               load      = 1'b1;
               kind_in   = KIND_WORD;
               oidx_in   = idx_ff;
               value_in  = {rd_hi, rd_lo};
               ofkind_in = fkind_ff;
               last_in   = (idx_ff == last_idx_ff);
               if (idx_ff == last_idx_ff) begin
                  words_done = 1'b1;
                  state_in   = B_IDLE;
               end else begin
                  idx_in   = idx_ff + 5'd1;
                  addr_in  = addr_ff + HALF_AW'(1);
                  state_in = B_READ;
               end
            end
         end
         default: begin
            if (head_valid) begin
               if (head_job.kind != KIND_WORD) begin
                  if (slot_free) begin
                     pop       = 1'b1;
                     load      = 1'b1;
                     kind_in   = head_job.kind;
                     oidx_in   = 5'd0;
                     value_in  = 16'd0;
                     ofkind_in = head_job.frame_kind;
                     last_in   = 1'b1;
                  end
               end else begin
                  pop         = 1'b1;
                  fkind_in    = head_job.frame_kind;
                  last_idx_in = head_job.full ? LAST_IDX_FULL : LAST_IDX_BASIC;
                  idx_in      = 5'd0;
                  addr_in     = WORD_BASE;
                  state_in    = B_READ;
               end
            end
         end
      endcase
      valid_in = load ? 1'b1 : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      fkind_ff    <= fkind_in;
      addr_ff     <= addr_in;
      kind_ff     <= kind_in;
      oidx_ff     <= oidx_in;
      value_ff    <= value_in;
      ofkind_ff   <= ofkind_in;
      last_ff     <= last_in;
   end

   assign rd_addr        = addr_ff;
   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_word_index = oidx_ff;
   assign rsp_word_value = value_ff;
   assign rsp_frame_kind = ofkind_ff;
   assign rsp_last       = last_ff;

endmodule

@@ hw/rtl/serial_telemetry_frame_receiver_unit.sv @@
// Bytes are taken one per cycle while a frame is parsed and req_stall is low; a
// status result passes through the job queue and the output register to rsp.
// A good frame of 34+ bytes yields 15 or 19 words from the even/odd byte stores,
// each read in B_READ and B_LOAD; input is stalled until the last word is loaded.
// Reset clears the parser and the result path; the byte store is not cleared.
module serial_telemetry_frame_receiver_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic [4:0]              rsp_word_index,
   output logic signed [15:0]      rsp_word_value,
   output logic [7:0]              rsp_frame_kind,
   output logic                    rsp_last,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  stfr_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_data
);

   import stfr_pkg::*;

   logic               push;
   job_type            push_job;
   logic               queue_full;
   logic               pop;
   logic               head_valid;
   job_type            head_job;
   logic               words_done;
   store_wr_type       store_wr;
   logic [HALF_AW-1:0] rd_addr;
   logic [7:0]         rd_hi;
   logic [7:0]         rd_lo;

   assign csr_ready = 1'b1;

   stfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .push        (push),
      .push_job    (push_job),
      .queue_full  (queue_full),
      .words_done  (words_done),
      .store_wr    (store_wr)
   );

   stfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   stfr_ram #(.WIDTH(8), .DEPTH(HALF_DEPTH)) u_store_even (
      .clock   (clock),
      .wr_en   (store_wr.en_even),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_hi)
   );

   stfr_ram #(.WIDTH(8), .DEPTH(HALF_DEPTH)) u_store_odd (
      .clock   (clock),
      .wr_en   (store_wr.en_odd),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_lo)
   );

   stfr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .words_done     (words_done),
      .rd_addr        (rd_addr),
      .rd_hi          (rd_hi),
      .rd_lo          (rd_lo),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_word_index (rsp_word_index),
      .rsp_word_value (rsp_word_value),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_last       (rsp_last)
   );

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_WORD |-> rsp_last && rsp_word_index == 5'd0
                                              && rsp_word_value == 16'sd0)
      else $error("status result malformed");

   a_bad_len_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_BAD_LEN |-> rsp_frame_kind == 8'd0)
      else $error("bad length result carries a frame kind");

   a_word_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_WORD |-> rsp_word_index <= LAST_IDX_FULL)
      else $error("word index out of range");

   a_words_block_input: assert property (@(posedge clock) disable iff (reset)
      push && push_job.kind == KIND_WORD |=> req_stall)
      else $error("input not held while words are emitted");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push)
      else $error("push into full job queue");

endmodule
